// ===== rtl/ntab_pkg.sv =====
// shared types and constants for the notification slot table
package ntab_pkg;

  localparam int REC_W  = 64;
  localparam int SLOT_W = 4;

  localparam logic [1:0] MODE_EVENT = 2'd0;
  localparam logic [1:0] MODE_POP   = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  localparam logic [15:0] VALID_LEN = 16'd8;

  localparam logic [2:0] ST_STORED  = 3'd0;
  localparam logic [2:0] ST_FULL    = 3'd1;
  localparam logic [2:0] ST_REMOVED = 3'd2;
  localparam logic [2:0] ST_BADLEN  = 3'd3;
  localparam logic [2:0] ST_POPPED  = 3'd4;
  localparam logic [2:0] ST_EMPTY   = 3'd5;
  localparam logic [2:0] ST_CLEARED = 3'd6;

  localparam logic [1:0] CFG_ADDR_REMOVED = 2'd0;
  localparam logic [7:0] REMOVED_RESET    = 8'd2;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_INIT_UP,
    OP_INIT_DOWN,
    OP_EV_STEP,
    OP_POP_STEP,
    OP_FIN_BADLEN,
    OP_FIN_REMOVED,
    OP_FIN_CLEAR,
    OP_FIN_EMPTY,
    OP_FIN_POP,
    OP_FIN_STORE
  } dp_op_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       len_ok;
    logic       removed;
    logic       ev_last;
    logic       pop_hit;
    logic       pop_last;
  } dp_stat_t;

endpackage

// ===== rtl/ntab_ram.sv =====
// generic single write port ram with registered read
module ntab_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

// ===== rtl/ntab_ctrl.sv =====
// controller state machine for the notification slot table
module ntab_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  ntab_pkg::dp_stat_t stat,
  output ntab_pkg::dp_op_t  op,
  output logic              busy
);
  import ntab_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_EV_SCAN,
    S_EV_WRITE,
    S_POP_SCAN,
    S_POP_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r;

  always_comb begin
    state_nxt = state_r;
    op        = OP_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          op        = OP_LOAD;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat.mode == MODE_EVENT) begin
          if (!stat.len_ok) begin
            op        = OP_FIN_BADLEN;
            state_nxt = S_IDLE;
          end else if (stat.removed) begin
            op        = OP_FIN_REMOVED;
            state_nxt = S_IDLE;
          end else begin
            op        = OP_INIT_UP;
            state_nxt = S_EV_SCAN;
          end
        end else if (stat.mode == MODE_POP) begin
          op        = OP_INIT_DOWN;
          state_nxt = S_POP_SCAN;
        end else begin
          op        = OP_FIN_CLEAR;
          state_nxt = S_IDLE;
        end
      end
      S_EV_SCAN: begin
        op = OP_EV_STEP;
        if (stat.ev_last) begin
          state_nxt = S_EV_WRITE;
        end
      end
      S_EV_WRITE: begin
        op        = OP_FIN_STORE;
        state_nxt = S_IDLE;
      end
      S_POP_SCAN: begin
        if (stat.pop_hit) begin
          state_nxt = S_POP_OUT;
        end else if (stat.pop_last) begin
          op        = OP_FIN_EMPTY;
          state_nxt = S_IDLE;
        end else begin
          op = OP_POP_STEP;
        end
      end
      S_POP_OUT: begin
        op        = OP_FIN_POP;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt != S_IDLE);
    end
  end

  assign busy = busy_r;

  a_busy_tracks_state: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r == (state_r != S_IDLE))
    else $error("busy out of step with state");

  a_accept_decodes: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy_r) |=> (state_r == S_DECODE))
    else $error("accepted word not decoded");

  a_pop_out_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_POP_SCAN && stat.pop_hit) |=> (state_r == S_POP_OUT))
    else $error("pop hit not followed by output");

endmodule

// ===== rtl/ntab_dp.sv =====
// datapath: item registers, valid bits, record memory, scan and result registers
module ntab_dp #(
  parameter int LIST_ENTRIES = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ntab_pkg::dp_op_t   op,
  input  logic [1:0]         in_mode,
  input  logic [15:0]        in_value_length,
  input  logic [7:0]         in_event_code,
  input  logic [7:0]         in_event_flag_bits,
  input  logic [7:0]         in_category_code,
  input  logic [7:0]         in_category_total,
  input  logic [31:0]        in_note_uid,
  input  logic [7:0]         removed_code,
  output ntab_pkg::dp_stat_t stat,
  output logic               out_valid,
  output logic [2:0]         out_status,
  output logic [3:0]         out_slot,
  output logic [7:0]         out_event,
  output logic [7:0]         out_flags,
  output logic [7:0]         out_category,
  output logic [7:0]         out_count,
  output logic [31:0]        out_uid
);
  import ntab_pkg::*;

  localparam int IW = (LIST_ENTRIES > 1) ? $clog2(LIST_ENTRIES) : 1;
  localparam logic [IW-1:0] LAST = IW'(LIST_ENTRIES - 1);

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  slot;
    logic [7:0]  ev;
    logic [7:0]  fl;
    logic [7:0]  cat;
    logic [7:0]  cnt;
    logic [31:0] uid;
  } res_t;

  logic [1:0]  mode_r;
  logic [15:0] len_r;
  logic [7:0]  ev_r, fl_r, cat_r, cnt_r;
  logic [31:0] uid_r;

  logic [LIST_ENTRIES-1:0] valid_r;
  logic [IW-1:0]           idx_r, chk_idx_r, match_idx_r, free_idx_r;
  logic                    chk_vld_r, iss_done_r, match_found_r, free_found_r;
  logic                    out_valid_r;
  res_t                    res_r, res_nxt;

  logic [REC_W-1:0] rd_rec, wr_rec;
  logic [IW-1:0]    wr_idx;
  logic             ram_we, chk_hit, chk_free, is_fin, have_slot;

  assign wr_idx    = match_found_r ? match_idx_r : free_idx_r;
  assign have_slot = match_found_r || free_found_r;
  assign ram_we    = (op == OP_FIN_STORE) && have_slot;
  assign wr_rec    = {uid_r, cnt_r, cat_r, fl_r, ev_r};

  ntab_ram #(
    .WIDTH (REC_W),
    .DEPTH (LIST_ENTRIES)
  ) u_rec_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_idx),
    .wdata (wr_rec),
    .raddr (idx_r),
    .rdata (rd_rec)
  );

  assign chk_hit  = chk_vld_r && valid_r[chk_idx_r] && (rd_rec[63:32] == uid_r);
  assign chk_free = chk_vld_r && !valid_r[chk_idx_r];

  assign stat.mode     = mode_r;
  assign stat.len_ok   = (len_r == VALID_LEN);
  assign stat.removed  = (ev_r == removed_code);
  assign stat.ev_last  = chk_vld_r && (chk_hit || chk_idx_r == LAST);
  assign stat.pop_hit  = valid_r[idx_r];
  assign stat.pop_last = (idx_r == '0);

  assign is_fin = (op == OP_FIN_BADLEN) || (op == OP_FIN_REMOVED) ||
                  (op == OP_FIN_CLEAR) || (op == OP_FIN_EMPTY) ||
                  (op == OP_FIN_POP) || (op == OP_FIN_STORE);

  always_comb begin
    res_nxt = '0;
    unique case (op)
      OP_FIN_BADLEN: res_nxt.status = ST_BADLEN;
      OP_FIN_REMOVED: begin
        res_nxt.status = ST_REMOVED;
        res_nxt.ev     = ev_r;
        res_nxt.fl     = fl_r;
        res_nxt.cat    = cat_r;
        res_nxt.cnt    = cnt_r;
        res_nxt.uid    = uid_r;
      end
      OP_FIN_CLEAR: res_nxt.status = ST_CLEARED;
      OP_FIN_EMPTY: res_nxt.status = ST_EMPTY;
      OP_FIN_POP: begin
        res_nxt.status = ST_POPPED;
        res_nxt.slot   = SLOT_W'(idx_r);
        res_nxt.ev     = rd_rec[7:0];
        res_nxt.fl     = rd_rec[15:8];
        res_nxt.cat    = rd_rec[23:16];
        res_nxt.cnt    = rd_rec[31:24];
        res_nxt.uid    = rd_rec[63:32];
      end
      OP_FIN_STORE: begin
        if (have_slot) begin
          res_nxt.status = ST_STORED;
          res_nxt.slot   = SLOT_W'(wr_idx);
        end else begin
          res_nxt.status = ST_FULL;
        end
      end
      default: begin
      end
    endcase
  end

  // control flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r       <= '0;
      chk_vld_r     <= 1'b0;
      iss_done_r    <= 1'b0;
      match_found_r <= 1'b0;
      free_found_r  <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      out_valid_r <= is_fin;
      chk_vld_r   <= (op == OP_EV_STEP) && !iss_done_r;
      unique case (op)
        OP_INIT_UP: begin
          iss_done_r    <= 1'b0;
          match_found_r <= 1'b0;
          free_found_r  <= 1'b0;
        end
        OP_EV_STEP: begin
          if (idx_r == LAST) begin
            iss_done_r <= 1'b1;
          end
          if (chk_hit) begin
            match_found_r <= 1'b1;
          end
          if (chk_free) begin
            free_found_r <= 1'b1;
          end
        end
        OP_FIN_STORE: begin
          if (have_slot) begin
            valid_r[wr_idx] <= 1'b1;
          end
        end
        OP_FIN_POP:   valid_r[idx_r] <= 1'b0;
        OP_FIN_CLEAR: valid_r <= '0;
        default: begin
        end
      endcase
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (is_fin) begin
      res_r <= res_nxt;
    end
    unique case (op)
      OP_LOAD: begin
        mode_r <= in_mode;
        len_r  <= in_value_length;
        ev_r   <= in_event_code;
        fl_r   <= in_event_flag_bits;
        cat_r  <= in_category_code;
        cnt_r  <= in_category_total;
        uid_r  <= in_note_uid;
      end
      OP_INIT_UP:   idx_r <= '0;
      OP_INIT_DOWN: idx_r <= LAST;
      OP_EV_STEP: begin
        chk_idx_r <= idx_r;
        if (!iss_done_r && idx_r != LAST) begin
          idx_r <= idx_r + 1'b1;
        end
        if (chk_hit) begin
          match_idx_r <= chk_idx_r;
        end
        if (chk_free && !free_found_r) begin
          free_idx_r <= chk_idx_r;
        end
      end
      OP_POP_STEP: idx_r <= idx_r - 1'b1;
      default: begin
      end
    endcase
  end

  assign out_valid    = out_valid_r;
  assign out_status   = res_r.status;
  assign out_slot     = res_r.slot;
  assign out_event    = res_r.ev;
  assign out_flags    = res_r.fl;
  assign out_category = res_r.cat;
  assign out_count    = res_r.cnt;
  assign out_uid      = res_r.uid;

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe longer than one cycle");

  a_pop_reads_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (op == OP_FIN_POP) |-> valid_r[idx_r])
    else $error("pop of an empty slot");

  a_match_is_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (op == OP_FIN_STORE && match_found_r) |-> valid_r[match_idx_r])
    else $error("uid match on an empty slot");

endmodule

// ===== rtl/notification_slot_table_core.sv =====
// top level of the notification slot table: config register, controller and datapath
//
// one word is taken at a clock edge with start high and busy low; busy then
// stays high until the word's single result is produced. the result appears
// on the out_ ports for exactly one cycle, marked by out_valid; the receiver
// cannot stall it, and a new word may be started in the result cycle.
// after the accepting edge the word is decoded; then:
//   bad length, removal forwarding, clear: the result follows the decode
//   event store: scans up to all LIST_ENTRIES slots, ending early on a uid match
//   pop: scans down from the top slot, ending early at the first valid slot
// the scans run through the record memory, whose one read port scans one slot
// per cycle. only one word is in flight at a time.
// reset (rst_n low, synchronous) clears all valid bits and sets the removal
// event code to 2; record contents are not cleared and need no sweep.
// the removal event code sits at apb byte address 0; the user must write it only
// while busy is low, as the block itself does not enforce this.
module notification_slot_table_core #(
  parameter int LIST_ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_mode,
  input  logic [15:0] in_value_length,
  input  logic [7:0]  in_event_code,
  input  logic [7:0]  in_event_flag_bits,
  input  logic [7:0]  in_category_code,
  input  logic [7:0]  in_category_total,
  input  logic [31:0] in_note_uid,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [3:0]  out_slot,
  output logic [7:0]  out_event,
  output logic [7:0]  out_flags,
  output logic [7:0]  out_category,
  output logic [7:0]  out_count,
  output logic [31:0] out_uid,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ntab_pkg::*;

  logic [7:0] removed_code_r;
  dp_op_t     op;
  dp_stat_t   stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      removed_code_r <= REMOVED_RESET;
    end else if (psel && penable && pwrite && paddr == CFG_ADDR_REMOVED) begin
      removed_code_r <= pwdata[7:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == CFG_ADDR_REMOVED) ? {24'd0, removed_code_r} : 32'd0;

  ntab_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .op    (op),
    .busy  (busy)
  );

  ntab_dp #(
    .LIST_ENTRIES (LIST_ENTRIES)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .op                 (op),
    .in_mode            (in_mode),
    .in_value_length    (in_value_length),
    .in_event_code      (in_event_code),
    .in_event_flag_bits (in_event_flag_bits),
    .in_category_code   (in_category_code),
    .in_category_total  (in_category_total),
    .in_note_uid        (in_note_uid),
    .removed_code       (removed_code_r),
    .stat               (stat),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_slot           (out_slot),
    .out_event          (out_event),
    .out_flags          (out_flags),
    .out_category       (out_category),
    .out_count          (out_count),
    .out_uid            (out_uid)
  );

endmodule
